[sv/lgr_pkg.sv]
// Shared types and constants for the look-ahead gain ramp block.
package lgr_pkg;

  // Default number of entries in the delay line.
  localparam int DEFAULT_STORE_DEPTH = 256;

  // Width of a gain sample in Q8.8.
  localparam int GAIN_W = 16;

  // Width of the ramp step dividend, magnitude of a Q8.16 gain.
  localparam int DIV_W = 24;

  // Width of the signed Q8.16 ramp accumulator, with headroom.
  localparam int RAMP_W = 26;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     shift;
    logic                     pass_ok;
    logic signed [RAMP_W-1:0] ramp;
    logic signed [GAIN_W-1:0] ramp_q8;
    logic signed [GAIN_W-1:0] shift_value;
  } cell_ctl_t;

endpackage

[sv/lgr_cell.sv]
// One cell of the delay line: one stored gain entry and the walk token.
module lgr_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  lgr_pkg::cell_ctl_t                 ctl,
  input  logic signed [lgr_pkg::GAIN_W-1:0]  data_in,
  input  logic                               token_in,
  output logic signed [lgr_pkg::GAIN_W-1:0]  entry,
  output logic                               token,
  output logic                               pass
);

  logic signed [lgr_pkg::RAMP_W-1:0] entry_q16;
  logic                              above;

  // Entry widened to Q8.16 and compared with the ramp.
  assign entry_q16 = {{(lgr_pkg::RAMP_W - lgr_pkg::GAIN_W - 8){entry[lgr_pkg::GAIN_W-1]}},
                      entry, 8'h00};
  assign above = (entry_q16 > ctl.ramp);
  assign pass  = token && above && ctl.pass_ok;

  // Shift on a new beat, otherwise take the token and clamp under the ramp.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      token <= 1'b0;
    end else if (ctl.shift) begin
      entry <= data_in;
      token <= 1'b0;
    end else begin
      token <= token_in;
      if (token && above) begin
        entry <= ctl.ramp_q8;
      end
    end
  end

endmodule

[sv/lgr_divider.sv]
// Restoring divider, one quotient bit per cycle, for the ramp step.
module lgr_divider #(
  parameter int IW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lgr_pkg::DIV_W-1:0]  dividend,
  input  logic [IW-1:0]              divisor,
  output logic                       done,
  output logic [lgr_pkg::DIV_W-1:0]  quotient
);

  localparam int CW = $clog2(lgr_pkg::DIV_W + 1);

  logic [CW-1:0] count;
  logic [IW-1:0] rem;
  logic [IW:0]   trial;
  logic          fits;

  // Bring down the next dividend bit and try a subtract.
  assign trial = {rem, quotient[lgr_pkg::DIV_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Iterate over all dividend bits, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count    <= CW'(lgr_pkg::DIV_W);
      rem      <= '0;
      quotient <= dividend;
      done     <= 1'b0;
    end else if (count != '0) begin
      count    <= count - 1'b1;
      rem      <= fits ? IW'(trial - {1'b0, divisor}) : IW'(trial);
      quotient <= {quotient[lgr_pkg::DIV_W-2:0], fits};
      done     <= (count == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[sv/lookahead_gain_ramp_unit.sv]
// Top level of the look-ahead gain ramp: sequencer, divider and cell row.
//
//   channel   direction  handshake                        payload
//   input     in         in_valid / in_stall              gain_db
//   output    out        out_valid / out_stall            smoothed_gain_db
//   config    in         cfg_write_en                     cfg_write_data
//
// An item goes from acceptance through DIVIDE, where the divider makes its 24
// iterations, and WALK, where the token walks one cell per cycle, to FINISH; with
// a delay of zero it goes straight to FINISH. The walk ends early at the first
// entry at or below the ramp.
// Reset clears the delay line, the delay register and all control state.
// The result waits in an output register; while it is stalled, the next item holds
// in its last step and the input stalls.
module lookahead_gain_ramp_unit #(
  parameter int STORE_DEPTH = lgr_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [lgr_pkg::GAIN_W-1:0]  gain_db,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lgr_pkg::GAIN_W-1:0]  smoothed_gain_db,
  input  logic                               cfg_write_en,
  input  logic [7:0]                         cfg_write_data
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int DW = (IW > 8) ? IW : 8;

  typedef enum logic [1:0] {IDLE, DIVIDE, WALK, FINISH} state_t;

  state_t                            state;
  logic [7:0]                        delay_samples;
  logic [IW-1:0]                     d_eff;
  logic [IW-1:0]                     d_r;
  logic [IW-1:0]                     k;
  logic signed [lgr_pkg::GAIN_W-1:0] v_clip;
  logic signed [lgr_pkg::GAIN_W-1:0] v_r;
  logic [lgr_pkg::GAIN_W-1:0]        neg_v;
  logic signed [lgr_pkg::RAMP_W-1:0] ramp;
  logic signed [lgr_pkg::RAMP_W-1:0] step;
  logic signed [lgr_pkg::RAMP_W-1:0] ramp_neg;
  logic                              accept;
  logic                              div_start;
  logic                              div_done;
  logic [lgr_pkg::DIV_W-1:0]         quotient;
  logic                              tok_start;
  logic                              any_tok;
  lgr_pkg::cell_ctl_t                ctl;
  logic signed [lgr_pkg::GAIN_W-1:0] entries [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]            tokens;
  logic [STORE_DEPTH-1:0]            passes;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
    end else if (cfg_write_en) begin
      delay_samples <= cfg_write_data;
    end
  end

  // Delay in effect, saturated to one less than the line length, and the clipped input.
  assign d_eff  = (DW'(delay_samples) > DW'(STORE_DEPTH - 1)) ? IW'(STORE_DEPTH - 1)
                                                              : IW'(delay_samples);
  assign v_clip = gain_db[lgr_pkg::GAIN_W-1] ? gain_db : '0;
  assign neg_v  = lgr_pkg::GAIN_W'(-v_r);

  // Handshake and sequencing strobes.
  assign in_stall  = (state != IDLE);
  assign accept    = in_valid && (state == IDLE);
  assign div_start = (state == DIVIDE) && (k == '0);
  assign tok_start = (state == DIVIDE) && div_done;
  assign any_tok   = |tokens;

  // Ramp truncated toward zero to Q8.8.
  assign ramp_neg = -ramp;

  // Broadcast to the cells.
  always_comb begin
    ctl.shift       = accept;
    ctl.pass_ok     = (k != d_r);
    ctl.ramp        = ramp;
    ctl.ramp_q8     = -lgr_pkg::GAIN_W'(ramp_neg >>> 8);
    ctl.shift_value = v_clip;
  end

  lgr_divider #(.IW(IW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({neg_v, 8'h00}),
    .divisor  (d_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Row of cells; cell zero holds the newest entry.
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic                              tin;
    logic signed [lgr_pkg::GAIN_W-1:0] din;
    if (i == 0) begin : g_head
      assign tin = 1'b0;
      assign din = ctl.shift_value;
    end else if (i == 1) begin : g_first
      assign tin = passes[0] | tok_start;
      assign din = entries[0];
    end else begin : g_rest
      assign tin = passes[i-1];
      assign din = entries[i-1];
    end
    lgr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .data_in  (din),
      .token_in (tin),
      .entry    (entries[i]),
      .token    (tokens[i]),
      .pass     (passes[i])
    );
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && !out_stall && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            d_r   <= d_eff;
            v_r   <= v_clip;
            k     <= '0;
            state <= (d_eff == '0) ? FINISH : DIVIDE;
          end
        end
        DIVIDE: begin
          if (k == '0) begin
            k <= IW'(1);
          end
          if (div_done) begin
            step  <= lgr_pkg::RAMP_W'(quotient);
            ramp  <= lgr_pkg::RAMP_W'($signed({v_r, 8'h00})) + lgr_pkg::RAMP_W'(quotient);
            state <= WALK;
          end
        end
        WALK: begin
          ramp <= ramp + step;
          k    <= k + 1'b1;
          if (!any_tok || (k == d_r)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            smoothed_gain_db <= entries[d_r];
            state            <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // At most one cell carries the walk token.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tokens))
    else $error("more than one walk token");

  // No token is left over once the block is idle.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> (tokens == '0))
    else $error("walk token left while idle");

  // Results are never positive.
  a_nonpos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smoothed_gain_db[lgr_pkg::GAIN_W-1] || (smoothed_gain_db == '0)))
    else $error("positive result");
`endif

endmodule

[test/testbench.sv]
// Testbench for the look-ahead gain ramp unit: directed and random beats against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH = lgr_pkg::DEFAULT_STORE_DEPTH;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [lgr_pkg::GAIN_W-1:0] gain_db = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [lgr_pkg::GAIN_W-1:0] smoothed_gain_db;
  logic cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = '0;

  // Predictor state.
  logic signed [lgr_pkg::GAIN_W-1:0] line_mem [DEPTH];
  int unsigned wr_ptr;
  int unsigned delay_cfg;
  logic signed [lgr_pkg::GAIN_W-1:0] gain_expected [$];

  int fail_count = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;
  int hold_cycles = 0;

  lookahead_gain_ramp_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .gain_db(gain_db),
    .out_valid(out_valid), .out_stall(out_stall), .smoothed_gain_db(smoothed_gain_db),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ramp smoothing of the delay line for one new sample; returns the delayed entry.
  function automatic logic signed [lgr_pkg::GAIN_W-1:0] smooth_sample(
      logic signed [lgr_pkg::GAIN_W-1:0] g);
    int signed v;
    int unsigned d, newest, idx, k;
    longint signed step, ramp, entry, mag;
    v = g;
    d = (delay_cfg > DEPTH - 1) ? DEPTH - 1 : delay_cfg;
    if (v > 0) v = 0;
    newest = wr_ptr;
    line_mem[newest] = lgr_pkg::GAIN_W'(v);
    wr_ptr = (newest + 1) % DEPTH;
    if (d > 0) begin
      step = (longint'(-v) * 256) / longint'(d);
      ramp = longint'(v) * 256 + step;
      for (k = 1; k <= d; k++) begin
        idx = (newest + DEPTH - k) % DEPTH;
        entry = longint'(line_mem[idx]) * 256;
        if (entry > ramp) begin
          mag = (ramp >= 0) ? ramp / 256 : -((-ramp) / 256);
          line_mem[idx] = lgr_pkg::GAIN_W'(mag);
          ramp += step;
        end else begin
          break;
        end
      end
    end
    return line_mem[(newest + DEPTH - d) % DEPTH];
  endfunction

  // Receiver stall: random idling, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= idle_enable && ($urandom_range(99) < 16);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (gain_expected.size() == 0) begin
        $error("unexpected beat smoothed_gain_db=%0d", smoothed_gain_db);
        fail_count <= fail_count + 1;
      end else begin
        if (smoothed_gain_db !== gain_expected[0]) begin
          $error("smoothed_gain_db expected %0d actual %0d", gain_expected[0],
                 smoothed_gain_db);
          fail_count <= fail_count + 1;
        end
        void'(gain_expected.pop_front());
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one beat, with optional idle cycles before it; valid stays up afterward.
  task automatic send_gain(logic signed [lgr_pkg::GAIN_W-1:0] g);
    while (idle_enable && ($urandom_range(99) < 16)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    gain_db <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gain_expected.push_back(smooth_sample(g));
    @(negedge clk);
  endtask

  // Wait for all results, then let the block settle before a register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (gain_expected.size() != 0) @(negedge clk);
    repeat (delay_cfg + 40) @(negedge clk);
  endtask

  task automatic write_delay(logic [7:0] d);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= d;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    delay_cfg = d;
  endtask

  // Random sample: mostly negative decays, some zero and positive noise.
  function automatic logic signed [lgr_pkg::GAIN_W-1:0] rand_gain();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'sd0;
    if (r < 20) return lgr_pkg::GAIN_W'($urandom);
    if (r < 30) return -$signed({1'b0, 15'($urandom)});
    return -$signed(16'($urandom_range(3000)));
  endfunction

  task automatic test_zero_delay();
    write_delay(8'd0);
    send_gain(16'sh7fff);
    send_gain(16'sh8000);
    send_gain(16'sd0);
    send_gain(-16'sd1);
    send_gain(16'sd1);
  endtask

  task automatic test_extremes();
    write_delay(8'd255);
    send_gain(16'sh8000);
    send_gain(16'sd0);
    send_gain(16'sh7fff);
    send_gain(16'sh8000);
    write_delay(8'd1);
    send_gain(-16'sd256);
    send_gain(16'sd0);
    send_gain(16'sh8000);
    send_gain(16'sd5);
    write_delay(8'd4);
    send_gain(-16'sd100);
    send_gain(-16'sd400);
    send_gain(-16'sd50);
    send_gain(16'sd0);
    send_gain(-16'sd3);
    send_gain(16'sh8000);
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    write_delay(8'd2);
    hold_cycles = 400;
    repeat (20) send_gain(rand_gain());
  endtask

  task automatic test_random();
    int n;
    int unsigned d;
    for (n = 0; n < 1500; n++) begin
      if (n % 100 == 0) begin
        d = $urandom_range(99);
        if (d < 40) d = $urandom_range(8);
        else if (d < 85) d = $urandom_range(40);
        else d = $urandom_range(255);
        write_delay(8'(d));
      end
      idle_enable = !(n >= 600 && n < 800);
      send_gain(rand_gain());
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    int k;
    for (k = 0; k < DEPTH; k++) line_mem[k] = '0;
    wr_ptr = 0;
    delay_cfg = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_zero_delay();
    test_extremes();
    test_backpressure();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lgr_pkg.sv
sv/lgr_cell.sv
sv/lgr_divider.sv
sv/lookahead_gain_ramp_unit.sv
test/testbench.sv
